[rtl/ea2bv_pkg.sv]
// Shared constants and fixed-point helpers for the Euler angle basis block.
package ea2bv_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned FRAC_Q = 30;
   localparam int unsigned TABLE_DEPTH = 32;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type CORDIC_X0 = 32'sd652032874;
   localparam word_type MUL_ROUND = 32'sd536870912;

   localparam word_type ATAN_TABLE [TABLE_DEPTH] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   function automatic word_type mul_q30(input word_type a, input word_type b);
      logic signed [2*WORD_BITS-1:0] aw;
      logic signed [2*WORD_BITS-1:0] bw;
      logic signed [2*WORD_BITS-1:0] p;
      aw = a;
      bw = b;
      p = (aw * bw) + (2*WORD_BITS)'(MUL_ROUND);
      return p[FRAC_Q+WORD_BITS-1:FRAC_Q];
   endfunction

endpackage

[rtl/ea2bv_cordic.sv]
// Pipelined rotation-mode CORDIC giving sine and cosine of one binary angle.
module ea2bv_cordic import ea2bv_pkg::*; #(
   parameter int unsigned ANGLE_BITS = 16,
   parameter int unsigned SINE_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [ANGLE_BITS-1:0] angle,
   output word_type              sine,
   output word_type              cosine
);

   word_type x_ff [SINE_STAGES+1];
   word_type y_ff [SINE_STAGES+1];
   word_type z_ff [SINE_STAGES+1];
   logic     flip_ff [SINE_STAGES+1];
   word_type sine_ff;
   word_type cosine_ff;

   logic [WORD_BITS-1:0] z32;
   logic                 flip_in;
   logic [WORD_BITS-1:0] z_prep;

   always_comb begin
      z32     = {angle, {(WORD_BITS-ANGLE_BITS){1'b0}}};
      flip_in = z32[WORD_BITS-1] ^ z32[WORD_BITS-2];
      z_prep  = {z32[WORD_BITS-1] ^ flip_in, z32[WORD_BITS-2:0]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= word_type'(z_prep);
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 0; k < SINE_STAGES; k++) begin : g_stage
      word_type dx, dy;
      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            flip_ff[k+1] <= flip_ff[k];
            if (!z_ff[k][WORD_BITS-1]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - ATAN_TABLE[k];
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + ATAN_TABLE[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff   <= flip_ff[SINE_STAGES] ? -y_ff[SINE_STAGES] : y_ff[SINE_STAGES];
         cosine_ff <= flip_ff[SINE_STAGES] ? -x_ff[SINE_STAGES] : x_ff[SINE_STAGES];
      end
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

[rtl/ea2bv_combine.sv]
// Product, sum, rounding and clamping stages forming the three basis vectors.
module ea2bv_combine import ea2bv_pkg::*; #(
   parameter int unsigned FRACTION_BITS = 14
) (
   input  logic                          clock,
   input  logic                          advance,
   input  word_type                      sp,
   input  word_type                      cp,
   input  word_type                      sy,
   input  word_type                      cy,
   input  word_type                      sr,
   input  word_type                      cr,
   output logic signed [FRACTION_BITS+1:0] forward_x,
   output logic signed [FRACTION_BITS+1:0] forward_y,
   output logic signed [FRACTION_BITS+1:0] forward_z,
   output logic signed [FRACTION_BITS+1:0] right_x,
   output logic signed [FRACTION_BITS+1:0] right_y,
   output logic signed [FRACTION_BITS+1:0] right_z,
   output logic signed [FRACTION_BITS+1:0] up_x,
   output logic signed [FRACTION_BITS+1:0] up_y,
   output logic signed [FRACTION_BITS+1:0] up_z
);

   localparam int unsigned OUT_W = FRACTION_BITS + 2;
   localparam int unsigned SH = FRAC_Q - FRACTION_BITS;
   localparam logic signed [33:0] RND = (34'sd1 <<< SH) >>> 1;
   localparam logic signed [33:0] LIM = 34'sd1 <<< FRACTION_BITS;

   typedef logic signed [OUT_W-1:0] out_type;

   function automatic out_type to_out(input logic signed [32:0] v);
      logic signed [33:0] t;
      t = ($signed({v[32], v}) + RND) >>> SH;
      if (t > LIM) t = LIM;
      if (t < -LIM) t = -LIM;
      return t[OUT_W-1:0];
   endfunction

   word_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   word_type srcp_ff, srsy_ff, srcy_ff, crcp_ff, sp_ff, cy_ff, sy_ff;

   word_type a_cpcy_ff, a_cpsy_ff, a_crsy_ff, a_crcy_ff, a_srcp_ff;
   word_type a_srsy_ff, a_srcy_ff, a_crcp_ff, a_sp_ff;
   word_type srspcy_ff, srspsy_ff, crspcy_ff, crspsy_ff;

   out_type fx_ff, fy_ff, fz_ff, rx_ff, ry_ff, rz_ff, ux_ff, uy_ff, uz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         srsp_ff <= mul_q30(sr, sp);
         crsp_ff <= mul_q30(cr, sp);
         cpcy_ff <= mul_q30(cp, cy);
         cpsy_ff <= mul_q30(cp, sy);
         crsy_ff <= mul_q30(cr, sy);
         crcy_ff <= mul_q30(cr, cy);
         srcp_ff <= mul_q30(sr, cp);
         srsy_ff <= mul_q30(sr, sy);
         srcy_ff <= mul_q30(sr, cy);
         crcp_ff <= mul_q30(cr, cp);
         sp_ff   <= sp;
         cy_ff   <= cy;
         sy_ff   <= sy;

         srspcy_ff <= mul_q30(srsp_ff, cy_ff);
         srspsy_ff <= mul_q30(srsp_ff, sy_ff);
         crspcy_ff <= mul_q30(crsp_ff, cy_ff);
         crspsy_ff <= mul_q30(crsp_ff, sy_ff);
         a_cpcy_ff <= cpcy_ff;
         a_cpsy_ff <= cpsy_ff;
         a_crsy_ff <= crsy_ff;
         a_crcy_ff <= crcy_ff;
         a_srcp_ff <= srcp_ff;
         a_srsy_ff <= srsy_ff;
         a_srcy_ff <= srcy_ff;
         a_crcp_ff <= crcp_ff;
         a_sp_ff   <= sp_ff;

         fx_ff <= to_out(33'(a_cpcy_ff));
         fy_ff <= to_out(33'(a_cpsy_ff));
         fz_ff <= to_out(-33'(a_sp_ff));
         rx_ff <= to_out(33'(a_crsy_ff) - 33'(srspcy_ff));
         ry_ff <= to_out(-33'(srspsy_ff) - 33'(a_crcy_ff));
         rz_ff <= to_out(-33'(a_srcp_ff));
         ux_ff <= to_out(33'(crspcy_ff) + 33'(a_srsy_ff));
         uy_ff <= to_out(33'(crspsy_ff) - 33'(a_srcy_ff));
         uz_ff <= to_out(33'(a_crcp_ff));
      end
   end

   assign forward_x = fx_ff;
   assign forward_y = fy_ff;
   assign forward_z = fz_ff;
   assign right_x   = rx_ff;
   assign right_y   = ry_ff;
   assign right_z   = rz_ff;
   assign up_x      = ux_ff;
   assign up_y      = uy_ff;
   assign up_z      = uz_ff;

endmodule

[rtl/euler_angles_to_basis_vectors_top.sv]
// Top level: turns pitch, yaw and roll binary angles into forward, right, up vectors.
//
// Usage:
//   Input channel req_*: pitch, yaw and roll as binary angles, 2^ANGLE_BITS
//   units per turn. Result channel rsp_*: nine signed Q1.FRACTION_BITS
//   components, clamped to plus or minus 2^FRACTION_BITS.
//   Both channels transfer on valid and ready high at a rising clock edge.
//   The pipeline has one angle prepare stage, one stage per CORDIC
//   iteration, one sign stage, two multiply stages and one sum, round
//   and clamp stage. Throughput is one transfer per cycle while the
//   receiver does not stall; the pipeline of three CORDIC units and the
//   two multiply stages accepts a new item every cycle unless stalled.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and req_ready drops in the same cycle; nothing is lost or repeated.
//   Synchronous reset clears all valid bits; payload registers keep
//   whatever they hold. No configuration, no state between items.
module euler_angles_to_basis_vectors_top import ea2bv_pkg::*; #(
   parameter int unsigned ANGLE_BITS = 16,
   parameter int unsigned FRACTION_BITS = 14,
   parameter int unsigned SINE_STAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ANGLE_BITS-1:0]           req_pitch_angle,
   input  logic [ANGLE_BITS-1:0]           req_yaw_angle,
   input  logic [ANGLE_BITS-1:0]           req_roll_angle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [FRACTION_BITS+1:0] rsp_forward_x,
   output logic signed [FRACTION_BITS+1:0] rsp_forward_y,
   output logic signed [FRACTION_BITS+1:0] rsp_forward_z,
   output logic signed [FRACTION_BITS+1:0] rsp_right_x,
   output logic signed [FRACTION_BITS+1:0] rsp_right_y,
   output logic signed [FRACTION_BITS+1:0] rsp_right_z,
   output logic signed [FRACTION_BITS+1:0] rsp_up_x,
   output logic signed [FRACTION_BITS+1:0] rsp_up_y,
   output logic signed [FRACTION_BITS+1:0] rsp_up_z
);

   localparam int unsigned LATENCY = SINE_STAGES + 5;

   logic [LATENCY-1:0] valid_ff, valid_in;
   logic               advance;
   word_type           sp, cp, sy, cy, sr, cr;

   assign advance   = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = {valid_ff[LATENCY-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   ea2bv_cordic #(.ANGLE_BITS(ANGLE_BITS), .SINE_STAGES(SINE_STAGES)) u_pitch (
      .clock(clock), .advance(advance), .angle(req_pitch_angle), .sine(sp), .cosine(cp)
   );

   ea2bv_cordic #(.ANGLE_BITS(ANGLE_BITS), .SINE_STAGES(SINE_STAGES)) u_yaw (
      .clock(clock), .advance(advance), .angle(req_yaw_angle), .sine(sy), .cosine(cy)
   );

   ea2bv_cordic #(.ANGLE_BITS(ANGLE_BITS), .SINE_STAGES(SINE_STAGES)) u_roll (
      .clock(clock), .advance(advance), .angle(req_roll_angle), .sine(sr), .cosine(cr)
   );

   ea2bv_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
      .clock(clock), .advance(advance),
      .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .forward_x(rsp_forward_x), .forward_y(rsp_forward_y), .forward_z(rsp_forward_z),
      .right_x(rsp_right_x), .right_y(rsp_right_y), .right_z(rsp_right_z),
      .up_x(rsp_up_x), .up_y(rsp_up_y), .up_z(rsp_up_z)
   );

`ifndef SYNTHESIS
   localparam logic signed [FRACTION_BITS+1:0] OUT_LIM = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output stall");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_forward_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_forward_z <= OUT_LIM) && (rsp_forward_z >= -OUT_LIM))
      else $error("forward_z outside the clamp range");
`endif

endmodule
